// ===== rtl/sector_rle_expander_core_defines.svh =====
// assertion macros shared by the sector rle expander rtl
`ifndef SECTOR_RLE_EXPANDER_CORE_DEFINES_SVH
`define SECTOR_RLE_EXPANDER_CORE_DEFINES_SVH

// same-cycle implication, checked on i_clk outside reset
`define SRE_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on i_clk outside reset
`define SRE_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/sre_pkg.sv =====
// types and constants of the sector rle expander
package sre_pkg;

    // decoder phase
    typedef enum logic [3:0] {
        PH_IDLE,
        PH_LEN_HI,
        PH_TYPE,
        PH_RAW,
        PH_CNT_LO,
        PH_CNT_HI,
        PH_PAT0,
        PH_PAT1,
        PH_CHUNK_HDR,
        PH_LIT_LEN,
        PH_LITERAL,
        PH_BLK_COUNT,
        PH_BLK_FILL,
        PH_REPLAY
    } t_phase;

    // status reported at record end
    typedef enum logic [2:0] {
        ST_OK            = 3'd0,
        ST_BAD_TYPE      = 3'd1,
        ST_BLK_LARGE     = 3'd2,
        ST_BYTE_IN_REPLAY = 3'd3,
        ST_OVERRUN       = 3'd4
    } t_status;

    // command codes
    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_PULL = 1'b1;

    // record type codes
    localparam logic [1:0] REC_RAW     = 2'd0;
    localparam logic [1:0] REC_PATTERN = 2'd1;
    localparam logic [7:0] REC_TYPE_MAX = 8'd2;

    // chunk header code of a literal chunk
    localparam logic [7:0] CHUNK_LITERALS = 8'd0;

    localparam int unsigned TOTAL_W = 17;
    localparam int unsigned LEN_W   = 16;
    localparam int unsigned CHUNK_W = 14;
    localparam int unsigned BLOG_W  = 4;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

    // one result on its way to the output register
    typedef struct packed {
        logic               byte_valid;
        logic               from_mem;
        logic [7:0]         data;
        logic               rec_end;
        t_status            status;
        logic [TOTAL_W-1:0] total;
    } t_result;

endpackage

// ===== rtl/sre_if.sv =====
// valid/ready channels of the sector rle expander

// encoded byte or pull request
interface sre_in_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [7:0] in_byte;
    logic       start_req;

    modport source (output valid, command, in_byte, start_req, input ready);
    modport sink   (input valid, command, in_byte, start_req, output ready);
endinterface

// expanded byte or record close
interface sre_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_byte;
    logic        byte_valid;
    logic        record_end;
    logic [16:0] expanded_length;
    logic [2:0]  status;

    modport source (output valid, out_byte, byte_valid, record_end, expanded_length, status,
                    input ready);
    modport sink   (input valid, out_byte, byte_valid, record_end, expanded_length, status,
                    output ready);
endinterface

// ===== rtl/sector_rle_expander_core.sv =====
// sector rle expander: decodes one run-length coded sector record per start
//
// i_in carries one transaction per encoded byte (command 0) or per pull of a
// replayed byte (command 1); start_req with command 0 opens a new record and
// drops any pending one. o_out carries at most one transaction per input
// transaction: an expanded byte, a record close with length and status, or
// both. Bytes that give no result produce no output transaction.
// One input transaction is taken every cycle while i_in is ready. A result
// passes through the read stage, for the pattern store read (one synchronous
// port, registered data), and then the output register.
// Literal results take the same path so order is kept.
// The pattern store holds 2**BLOCK_LOG2_MAX bytes and is always written
// before it is replayed, so it needs no clearing pass after reset.
// Reset clears the decoder to idle and empties both result stages.
// When o_out stalls, the output register holds; one more result is parked
// in the read stage, and i_in drops ready only while both are full.
module sector_rle_expander_core #(
    parameter int unsigned BLOCK_LOG2_MAX = 9
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    sre_in_if.sink     i_in,
    sre_out_if.source  o_out
);
    import sre_pkg::*;

    `include "sector_rle_expander_core_defines.svh"

    localparam int unsigned AW          = BLOCK_LOG2_MAX;
    localparam int unsigned STORE_DEPTH = 1 << BLOCK_LOG2_MAX;
    localparam int unsigned IDXW        = BLOCK_LOG2_MAX + 1;

    // decoder state
    t_phase               r_phase, n_phase;
    logic [1:0]           r_kind, n_kind;
    logic [LEN_W-1:0]     r_enc, n_enc;
    logic [7:0]           r_low, n_low;
    logic [CHUNK_W-1:0]   r_chunk, n_chunk;
    logic [LEN_W-1:0]     r_rep, n_rep;
    logic [BLOG_W-1:0]    r_blog, n_blog;
    logic [IDXW-1:0]      r_idx, n_idx;
    logic [TOTAL_W-1:0]   r_total, n_total;

    // pattern store
    logic [7:0]           r_store [STORE_DEPTH];
    logic [7:0]           r_rdata;
    logic                 w_mem_we;
    logic [AW-1:0]        w_mem_wa;
    logic                 w_mem_rd;

    // result stages
    t_result              w_res;
    logic                 w_end;
    logic                 r_s2_valid;
    t_result              r_s2;
    logic                 r_ov;
    logic [7:0]           r_o_byte;
    logic                 r_o_bvalid;
    logic                 r_o_end;
    logic [TOTAL_W-1:0]   r_o_len;
    logic [2:0]           r_o_status;

    // helpers
    logic                 w_acc;
    logic                 w_out_take;
    logic [LEN_W-1:0]     w_enc_dec;
    logic [TOTAL_W-1:0]   w_total_inc;
    logic [IDXW-1:0]      w_idx_inc;
    logic [IDXW-1:0]      w_blk_size;
    logic [CHUNK_W-1:0]   w_chunk_dec;
    logic [LEN_W-1:0]     w_rep_dec;
    logic [LEN_W-1:0]     w_len;
    logic [TOTAL_W-1:0]   w_blk_need;
    logic [7:0]           w_b;

    // handshake
    assign w_out_take = !r_ov || o_out.ready;
    assign i_in.ready = !r_s2_valid || w_out_take;
    assign w_acc      = i_in.valid && i_in.ready;
    assign w_b        = i_in.in_byte;

    // counter arithmetic
    assign w_enc_dec   = (r_enc != '0) ? r_enc - LEN_W'(1) : r_enc;
    assign w_total_inc = (r_total != TOTAL_MAX) ? r_total + TOTAL_W'(1) : r_total;
    assign w_idx_inc   = r_idx + IDXW'(1);
    assign w_blk_size  = IDXW'(1) << r_blog;
    assign w_chunk_dec = (r_chunk != '0) ? r_chunk - CHUNK_W'(1) : r_chunk;
    assign w_rep_dec   = (r_rep != '0) ? r_rep - LEN_W'(1) : r_rep;
    assign w_len       = {w_b, r_low};
    assign w_blk_need  = (TOTAL_W'(1) << w_b[BLOG_W-1:0]) + TOTAL_W'(1);

    // next state and result of the current transaction
    always_comb begin
        n_phase  = r_phase;
        n_kind   = r_kind;
        n_enc    = r_enc;
        n_low    = r_low;
        n_chunk  = r_chunk;
        n_rep    = r_rep;
        n_blog   = r_blog;
        n_idx    = r_idx;
        n_total  = r_total;
        w_mem_we = 1'b0;
        w_mem_wa = '0;
        w_mem_rd = 1'b0;
        w_end    = 1'b0;
        w_res    = '0;
        w_res.status = ST_OK;

        if (i_in.command == CMD_PULL) begin
            if (r_phase == PH_REPLAY) begin
                w_mem_rd         = 1'b1;
                w_res.byte_valid = 1'b1;
                w_res.from_mem   = 1'b1;
                n_total          = w_total_inc;
                n_idx            = w_idx_inc;
                if (r_blog > BLOG_W'(BLOCK_LOG2_MAX) || w_idx_inc >= w_blk_size) begin
                    n_idx = '0;
                    n_rep = w_rep_dec;
                    if (w_rep_dec == '0) begin
                        if (r_kind == REC_PATTERN || r_enc == '0) begin
                            w_end = 1'b1;
                        end else begin
                            n_phase = PH_CHUNK_HDR;
                        end
                    end
                end
            end
        end else if (i_in.start_req) begin
            n_low   = w_b;
            n_total = '0;
            n_enc   = '0;
            n_chunk = '0;
            n_rep   = '0;
            n_idx   = '0;
            n_kind  = REC_RAW;
            n_phase = PH_LEN_HI;
        end else begin
            case (r_phase)
                PH_LEN_HI: begin
                    n_enc   = (w_len != '0) ? w_len - LEN_W'(1) : '0;
                    n_phase = PH_TYPE;
                end
                PH_TYPE: begin
                    if (w_b > REC_TYPE_MAX) begin
                        w_end        = 1'b1;
                        w_res.status = ST_BAD_TYPE;
                    end else begin
                        n_kind = w_b[1:0];
                        if (w_b[1:0] == REC_PATTERN) begin
                            n_phase = PH_CNT_LO;
                        end else if (r_enc == '0) begin
                            w_end = 1'b1;
                        end else begin
                            n_phase = (w_b[1:0] == REC_RAW) ? PH_RAW : PH_CHUNK_HDR;
                        end
                    end
                end
                PH_RAW: begin
                    n_enc            = w_enc_dec;
                    n_total          = w_total_inc;
                    w_res.byte_valid = 1'b1;
                    w_res.data       = w_b;
                    w_end            = (w_enc_dec == '0);
                end
                PH_CNT_LO: begin
                    n_low   = w_b;
                    n_phase = PH_CNT_HI;
                end
                PH_CNT_HI: begin
                    n_rep   = w_len;
                    n_phase = PH_PAT0;
                end
                PH_PAT0: begin
                    w_mem_we = 1'b1;
                    w_mem_wa = AW'(0);
                    n_phase  = PH_PAT1;
                end
                PH_PAT1: begin
                    w_mem_we = 1'b1;
                    w_mem_wa = AW'(1);
                    n_blog   = BLOG_W'(1);
                    n_idx    = '0;
                    if (r_rep == '0) begin
                        w_end = 1'b1;
                    end else begin
                        n_phase = PH_REPLAY;
                    end
                end
                PH_CHUNK_HDR: begin
                    n_enc = w_enc_dec;
                    if (w_b == CHUNK_LITERALS) begin
                        if (w_enc_dec == '0) begin
                            w_end        = 1'b1;
                            w_res.status = ST_OVERRUN;
                        end else begin
                            n_phase = PH_LIT_LEN;
                        end
                    end else if (w_b > 8'(BLOCK_LOG2_MAX)) begin
                        w_end        = 1'b1;
                        w_res.status = ST_BLK_LARGE;
                    end else begin
                        n_blog = w_b[BLOG_W-1:0];
                        if (w_blk_need > TOTAL_W'(w_enc_dec)) begin
                            w_end        = 1'b1;
                            w_res.status = ST_OVERRUN;
                        end else begin
                            n_phase = PH_BLK_COUNT;
                        end
                    end
                end
                PH_LIT_LEN: begin
                    n_enc = w_enc_dec;
                    if (LEN_W'(w_b) > w_enc_dec) begin
                        w_end        = 1'b1;
                        w_res.status = ST_OVERRUN;
                    end else if (w_b == 8'd0) begin
                        if (w_enc_dec == '0) begin
                            w_end = 1'b1;
                        end else begin
                            n_phase = PH_CHUNK_HDR;
                        end
                    end else begin
                        n_chunk = CHUNK_W'(w_b);
                        n_phase = PH_LITERAL;
                    end
                end
                PH_LITERAL: begin
                    n_enc            = w_enc_dec;
                    n_total          = w_total_inc;
                    n_chunk          = w_chunk_dec;
                    w_res.byte_valid = 1'b1;
                    w_res.data       = w_b;
                    if (w_chunk_dec == '0) begin
                        if (w_enc_dec == '0) begin
                            w_end = 1'b1;
                        end else begin
                            n_phase = PH_CHUNK_HDR;
                        end
                    end
                end
                PH_BLK_COUNT: begin
                    n_enc   = w_enc_dec;
                    n_rep   = LEN_W'(w_b);
                    n_chunk = CHUNK_W'(1) << r_blog;
                    n_idx   = '0;
                    n_phase = PH_BLK_FILL;
                end
                PH_BLK_FILL: begin
                    n_enc    = w_enc_dec;
                    w_mem_we = 1'b1;
                    w_mem_wa = r_idx[AW-1:0];
                    n_idx    = w_idx_inc;
                    n_chunk  = w_chunk_dec;
                    if (w_chunk_dec == '0) begin
                        n_idx = '0;
                        if (r_rep != '0) begin
                            n_phase = PH_REPLAY;
                        end else if (w_enc_dec == '0) begin
                            w_end = 1'b1;
                        end else begin
                            n_phase = PH_CHUNK_HDR;
                        end
                    end
                end
                PH_REPLAY: begin
                    w_end        = 1'b1;
                    w_res.status = ST_BYTE_IN_REPLAY;
                end
                default: begin
                end
            endcase
        end

        // record close
        w_res.rec_end = w_end;
        if (w_end) begin
            n_phase     = PH_IDLE;
            w_res.total = n_total;
        end else begin
            w_res.status = ST_OK;
        end
    end

    // decoder state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_kind  <= '0;
            r_enc   <= '0;
            r_low   <= '0;
            r_chunk <= '0;
            r_rep   <= '0;
            r_blog  <= '0;
            r_idx   <= '0;
            r_total <= '0;
        end else if (w_acc) begin
            r_phase <= n_phase;
            r_kind  <= n_kind;
            r_enc   <= n_enc;
            r_low   <= n_low;
            r_chunk <= n_chunk;
            r_rep   <= n_rep;
            r_blog  <= n_blog;
            r_idx   <= n_idx;
            r_total <= n_total;
        end
    end

    // pattern store, one write or one read per transaction
    always_ff @(posedge i_clk) begin
        if (w_acc && w_mem_we) begin
            r_store[w_mem_wa] <= w_b;
        end
        if (w_acc && w_mem_rd) begin
            r_rdata <= r_store[r_idx[AW-1:0]];
        end
    end

    // read stage: result waits here for the store data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_s2_valid <= w_acc && (w_res.byte_valid || w_res.rec_end);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_s2 <= w_res;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_out_take) begin
            r_ov <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s2_valid && w_out_take) begin
            r_o_byte   <= r_s2.from_mem ? r_rdata : r_s2.data;
            r_o_bvalid <= r_s2.byte_valid;
            r_o_end    <= r_s2.rec_end;
            r_o_len    <= r_s2.total;
            r_o_status <= r_s2.status;
        end
    end

    assign o_out.valid           = r_ov;
    assign o_out.out_byte        = r_o_byte;
    assign o_out.byte_valid      = r_o_bvalid;
    assign o_out.record_end      = r_o_end;
    assign o_out.expanded_length = r_o_len;
    assign o_out.status          = r_o_status;

    // checks
    `SRE_ASSERT_NXT(a_close_goes_idle, w_acc && w_end, r_phase == PH_IDLE,
        "decoder not idle after record close")
    `SRE_ASSERT_IMP(a_replay_idx_in_block, r_phase == PH_REPLAY, r_idx < w_blk_size,
        "replay index beyond block size")
    `SRE_ASSERT_IMP(a_store_write_phase, w_acc && w_mem_we,
        r_phase == PH_PAT0 || r_phase == PH_PAT1 || r_phase == PH_BLK_FILL,
        "pattern store written outside a fill phase")
    `SRE_ASSERT_IMP(a_length_only_at_end, o_out.valid && !o_out.record_end,
        o_out.expanded_length == '0 && o_out.status == 3'(ST_OK),
        "length or status set on a result that does not close the record")

endmodule

// ===== test/tb.sv =====
// testbench for the sector rle expander: record stimulus, result prediction and checking
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sre_pkg::*;

    localparam int unsigned BLOCK_LOG2_MAX = 9;
    localparam int unsigned STORE_DEPTH    = 1 << BLOCK_LOG2_MAX;
    localparam int unsigned MAX_REPORTS    = 10;
    localparam logic [7:0]  REC_CHUNKED    = 8'd2;

    typedef struct {
        logic [7:0]  out_byte;
        logic        byte_valid;
        logic        record_end;
        logic [16:0] expanded_length;
        t_status     status;
    } t_sector_result;

    logic i_clk = 1'b0;
    logic i_rst_n;

    sre_in_if  src_ch ();
    sre_out_if res_ch ();

    sector_rle_expander_core #(
        .BLOCK_LOG2_MAX(BLOCK_LOG2_MAX)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (src_ch),
        .o_out  (res_ch)
    );

    // clock
    always #2 i_clk = ~i_clk;

    // decoder image kept by the testbench
    t_phase      dec_phase;
    logic [1:0]  rec_kind;
    logic [15:0] enc_left;
    logic [7:0]  low_hold;
    logic [13:0] chunk_left;
    logic [15:0] rep_left;
    logic [3:0]  blk_log2;
    logic [7:0]  pat_mem [STORE_DEPTH];
    logic [12:0] rep_idx;
    logic [16:0] exp_total;

    t_sector_result expanded_q [$];
    int unsigned    mismatch_count = 0;
    int unsigned    effective_items = 0;

    // stimulus knobs
    int unsigned src_idle_pct = 0;
    int unsigned snk_stall_pct = 0;
    int unsigned intrude_pct = 0;
    int unsigned stall_left = 0;

    logic [7:0] payload [$];
    logic [7:0] rec_bytes [$];

    function automatic void clear_decoder();
        dec_phase  = PH_IDLE;
        rec_kind   = '0;
        enc_left   = '0;
        low_hold   = '0;
        chunk_left = '0;
        rep_left   = '0;
        blk_log2   = '0;
        rep_idx    = '0;
        exp_total  = '0;
        foreach (pat_mem[i]) pat_mem[i] = '0;
    endfunction

    // queue one expected result; a close returns the decoder to idle
    function automatic void push_result(logic [7:0] b, logic bv, logic re, t_status st);
        t_sector_result r;
        r.out_byte        = bv ? b : 8'd0;
        r.byte_valid      = bv;
        r.record_end      = re;
        r.expanded_length = re ? exp_total : '0;
        r.status          = re ? st : ST_OK;
        expanded_q = {expanded_q, r};
        if (re) dec_phase = PH_IDLE;
    endfunction

    function automatic void bump_total();
        if (exp_total != TOTAL_MAX) exp_total = exp_total + 1'b1;
    endfunction

    function automatic void take_enc();
        if (enc_left != 0) enc_left = enc_left - 1'b1;
    endfunction

    // chunk boundary: true when the record has no encoded bytes left
    function automatic bit record_tail();
        if (enc_left == 0) return 1'b1;
        dec_phase = PH_CHUNK_HDR;
        return 1'b0;
    endfunction

    // expected results of one accepted transaction
    function automatic void expand_step(logic cmd, logic [7:0] b, logic start);
        logic [7:0]  v;
        logic [15:0] lenv;
        bit          fin;
        if (cmd == CMD_PULL) begin
            if (dec_phase != PH_REPLAY) return;
            effective_items++;
            v = pat_mem[rep_idx[BLOCK_LOG2_MAX-1:0]];
            bump_total();
            rep_idx = rep_idx + 1'b1;
            fin = 1'b0;
            if (int'(rep_idx) >= (1 << blk_log2)) begin
                rep_idx = '0;
                if (rep_left != 0) rep_left = rep_left - 1'b1;
                if (rep_left == 0) begin
                    if (rec_kind == REC_PATTERN) fin = 1'b1;
                    else fin = record_tail();
                end
            end
            push_result(v, 1'b1, fin, ST_OK);
            return;
        end
        if (start) begin
            effective_items++;
            low_hold   = b;
            exp_total  = '0;
            enc_left   = '0;
            chunk_left = '0;
            rep_left   = '0;
            rep_idx    = '0;
            rec_kind   = REC_RAW;
            dec_phase  = PH_LEN_HI;
            return;
        end
        if (dec_phase != PH_IDLE) effective_items++;
        case (dec_phase)
            PH_LEN_HI: begin
                lenv      = {b, low_hold};
                enc_left  = (lenv != 0) ? lenv - 1'b1 : 16'd0;
                dec_phase = PH_TYPE;
            end
            PH_TYPE: begin
                if (b > REC_TYPE_MAX) begin
                    push_result(8'd0, 1'b0, 1'b1, ST_BAD_TYPE);
                end else begin
                    rec_kind = b[1:0];
                    if (b[1:0] == REC_PATTERN) dec_phase = PH_CNT_LO;
                    else if (enc_left == 0) push_result(8'd0, 1'b0, 1'b1, ST_OK);
                    else dec_phase = (b[1:0] == REC_RAW) ? PH_RAW : PH_CHUNK_HDR;
                end
            end
            PH_RAW: begin
                take_enc();
                bump_total();
                push_result(b, 1'b1, enc_left == 0, ST_OK);
            end
            PH_CNT_LO: begin
                low_hold  = b;
                dec_phase = PH_CNT_HI;
            end
            PH_CNT_HI: begin
                rep_left  = {b, low_hold};
                dec_phase = PH_PAT0;
            end
            PH_PAT0: begin
                pat_mem[0] = b;
                dec_phase  = PH_PAT1;
            end
            PH_PAT1: begin
                pat_mem[1] = b;
                blk_log2   = 4'd1;
                rep_idx    = '0;
                if (rep_left == 0) push_result(8'd0, 1'b0, 1'b1, ST_OK);
                else dec_phase = PH_REPLAY;
            end
            PH_CHUNK_HDR: begin
                take_enc();
                if (b == CHUNK_LITERALS) begin
                    if (enc_left == 0) push_result(8'd0, 1'b0, 1'b1, ST_OVERRUN);
                    else dec_phase = PH_LIT_LEN;
                end else if (b > BLOCK_LOG2_MAX) begin
                    push_result(8'd0, 1'b0, 1'b1, ST_BLK_LARGE);
                end else begin
                    blk_log2 = b[3:0];
                    if (1 + (1 << b) > int'(enc_left)) push_result(8'd0, 1'b0, 1'b1, ST_OVERRUN);
                    else dec_phase = PH_BLK_COUNT;
                end
            end
            PH_LIT_LEN: begin
                take_enc();
                if (b > enc_left) begin
                    push_result(8'd0, 1'b0, 1'b1, ST_OVERRUN);
                end else if (b == 0) begin
                    if (record_tail()) push_result(8'd0, 1'b0, 1'b1, ST_OK);
                end else begin
                    chunk_left = 14'(b);
                    dec_phase  = PH_LITERAL;
                end
            end
            PH_LITERAL: begin
                take_enc();
                bump_total();
                if (chunk_left != 0) chunk_left = chunk_left - 1'b1;
                fin = 1'b0;
                if (chunk_left == 0) fin = record_tail();
                push_result(b, 1'b1, fin, ST_OK);
            end
            PH_BLK_COUNT: begin
                take_enc();
                rep_left   = 16'(b);
                chunk_left = 14'(1 << blk_log2);
                rep_idx    = '0;
                dec_phase  = PH_BLK_FILL;
            end
            PH_BLK_FILL: begin
                take_enc();
                pat_mem[rep_idx[BLOCK_LOG2_MAX-1:0]] = b;
                rep_idx = rep_idx + 1'b1;
                if (chunk_left != 0) chunk_left = chunk_left - 1'b1;
                if (chunk_left == 0) begin
                    rep_idx = '0;
                    if (rep_left != 0) dec_phase = PH_REPLAY;
                    else if (record_tail()) push_result(8'd0, 1'b0, 1'b1, ST_OK);
                end
            end
            PH_REPLAY: push_result(8'd0, 1'b0, 1'b1, ST_BYTE_IN_REPLAY);
            default: ;
        endcase
    endfunction

    // mostly short gaps, a few long ones
    function automatic int gap_len();
        return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(8, 30);
    endfunction

    // result sink with random stalls
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else if (stall_left > 0) begin
            res_ch.ready <= 1'b0;
            stall_left--;
        end else if (snk_stall_pct != 0 && $urandom_range(0, 99) < snk_stall_pct) begin
            res_ch.ready <= 1'b0;
            stall_left = gap_len() - 1;
        end else begin
            res_ch.ready <= 1'b1;
        end
    end

    // compare each result transaction with the oldest expectation
    always @(posedge i_clk) begin
        t_sector_result want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (expanded_q.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("%0t: unexpected result byte=%02h bv=%0b end=%0b len=%0d st=%0d",
                             $realtime, res_ch.out_byte, res_ch.byte_valid, res_ch.record_end,
                             res_ch.expanded_length, res_ch.status);
            end else begin
                want = expanded_q.pop_front();
                if (res_ch.out_byte !== want.out_byte || res_ch.byte_valid !== want.byte_valid ||
                    res_ch.record_end !== want.record_end ||
                    res_ch.expanded_length !== want.expanded_length ||
                    res_ch.status !== want.status) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display({"%0t: mismatch expected byte=%02h bv=%0b end=%0b len=%0d st=%0d",
                                  " got byte=%02h bv=%0b end=%0b len=%0d st=%0d"}, $realtime,
                                 want.out_byte, want.byte_valid, want.record_end,
                                 want.expanded_length, want.status, res_ch.out_byte,
                                 res_ch.byte_valid, res_ch.record_end,
                                 res_ch.expanded_length, res_ch.status);
                end
            end
        end
    end

    // one input transaction, entered at a falling edge and left at a falling edge
    task automatic send_item(logic cmd, logic [7:0] b, logic start);
        if (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) begin
            src_ch.valid <= 1'b0;
            repeat (gap_len()) @(negedge i_clk);
        end
        src_ch.valid     <= 1'b1;
        src_ch.command   <= cmd;
        src_ch.in_byte   <= b;
        src_ch.start_req <= start;
        do @(posedge i_clk); while (src_ch.ready !== 1'b1);
        expand_step(cmd, b, start);
        @(negedge i_clk);
    endtask

    // hold the sender until every expected result has come
    task automatic drain_results();
        src_ch.valid <= 1'b0;
        do @(negedge i_clk); while (expanded_q.size() != 0);
    endtask

    // pull replayed bytes while replay is pending, sometimes giving up early
    task automatic serve_replay();
        while (dec_phase == PH_REPLAY) begin
            if (intrude_pct != 0 && $urandom_range(0, 99) < intrude_pct) break;
            send_item(CMD_PULL, 8'($urandom), $urandom_range(0, 9) == 0);
        end
    endtask

    task automatic send_record();
        for (int i = 0; i < rec_bytes.size(); i++) begin
            if (i > 0) serve_replay();
            send_item(CMD_BYTE, rec_bytes[i], i == 0);
        end
        serve_replay();
    endtask

    // record framing: length field, type byte, payload
    function automatic void frame_record(int len, logic [7:0] kind);
        rec_bytes = {len[7:0], len[15:8], kind, payload};
    endfunction

    function automatic void add_literal_chunk(int n);
        payload = {payload, CHUNK_LITERALS, 8'(n)};
        repeat (n) payload = {payload, 8'($urandom)};
    endfunction

    // block bytes only follow an exponent the block accepts
    function automatic void add_block_chunk(int k, int cnt);
        payload = {payload, 8'(k), 8'(cnt)};
        if (k <= BLOCK_LOG2_MAX) repeat (1 << k) payload = {payload, 8'($urandom)};
    endfunction

    // length field mostly right, sometimes zero, short or long
    function automatic int pick_len(int exact);
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) return exact;
        if (r < 86) return 0;
        if (r < 94) return (exact > 3) ? exact - int'($urandom_range(1, 3)) : $urandom_range(0, exact);
        return exact + int'($urandom_range(1, 3));
    endfunction

    function automatic void build_random_record();
        int sel, n, k, cnt, r;
        payload = {};
        sel = $urandom_range(0, 99);
        if (sel < 28) begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 80) : $urandom_range(0, 12);
            repeat (n) payload = {payload, 8'($urandom)};
            frame_record(pick_len(1 + n), 8'(REC_RAW));
        end else if (sel < 50) begin
            cnt = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 8) : $urandom_range(9, 60);
            payload = {8'(cnt), 8'(cnt >> 8), 8'($urandom), 8'($urandom)};
            frame_record($urandom_range(0, 65535), 8'(REC_PATTERN));
        end else if (sel < 95) begin
            repeat ($urandom_range(1, 4)) begin
                if ($urandom_range(0, 99) < 45) begin
                    add_literal_chunk(($urandom_range(0, 9) == 0) ? $urandom_range(11, 40)
                                                                  : $urandom_range(0, 10));
                end else begin
                    r = $urandom_range(0, 99);
                    if (r < 80) k = $urandom_range(1, 4);
                    else if (r < 95) k = $urandom_range(5, BLOCK_LOG2_MAX);
                    else k = $urandom_range(BLOCK_LOG2_MAX + 1, 255);
                    cnt = (k > 5) ? $urandom_range(0, 2) : $urandom_range(0, 6);
                    add_block_chunk(k, cnt);
                end
            end
            frame_record(pick_len(1 + payload.size()), REC_CHUNKED);
        end else begin
            repeat ($urandom_range(0, 3)) payload = {payload, 8'($urandom)};
            frame_record($urandom_range(0, 8), 8'($urandom_range(REC_TYPE_MAX + 1, 255)));
        end
    endfunction

    // raw records: byte extremes, zero length, type byte only
    task automatic test_raw_records();
        payload = {8'h00, 8'hFF, 8'hA5, 8'h5A};
        frame_record(1 + payload.size(), 8'(REC_RAW));
        send_record();
        payload = {};
        frame_record(0, 8'(REC_RAW));
        send_record();
        frame_record(1, 8'(REC_RAW));
        send_record();
        drain_results();
    endtask

    // pattern records: ignored length, zero count, count with high byte set
    task automatic test_pattern_records();
        payload = {8'd3, 8'd0, 8'h00, 8'hFF};
        frame_record(16'hFFFF, 8'(REC_PATTERN));
        send_record();
        payload = {8'd0, 8'd0, 8'hAA, 8'h55};
        frame_record(0, 8'(REC_PATTERN));
        send_record();
        payload = {8'h00, 8'h01, 8'hC3, 8'h3C};
        frame_record(4, 8'(REC_PATTERN));
        send_record();
        drain_results();
    endtask

    // chunked records: literals, blocks, zero-count block, empty chunk, largest block
    task automatic test_chunk_records();
        payload = {};
        add_literal_chunk(3);
        add_block_chunk(1, 2);
        add_block_chunk(2, 0);
        add_literal_chunk(0);
        frame_record(1 + payload.size(), REC_CHUNKED);
        send_record();
        payload = {};
        frame_record(1, REC_CHUNKED);
        send_record();
        add_block_chunk(BLOCK_LOG2_MAX, 1);
        frame_record(1 + payload.size(), REC_CHUNKED);
        send_record();
        drain_results();
    endtask

    // every error close
    task automatic test_error_closes();
        payload = {};
        frame_record(1, REC_TYPE_MAX + 8'd1);
        send_record();
        frame_record(16'h0100, 8'hFF);
        send_record();
        add_block_chunk(BLOCK_LOG2_MAX + 1, 1);
        frame_record(1 + payload.size() + 16, REC_CHUNKED);
        send_record();
        payload = {8'hFF, 8'h02};
        frame_record(1 + payload.size(), REC_CHUNKED);
        send_record();
        // chunk header on the last byte of the record
        payload = {CHUNK_LITERALS};
        frame_record(2, REC_CHUNKED);
        send_record();
        // literal count beyond the record
        payload = {CHUNK_LITERALS, 8'd5, 8'h01, 8'h02};
        frame_record(1 + payload.size(), REC_CHUNKED);
        send_record();
        // block beyond the record
        payload = {};
        add_block_chunk(3, 1);
        frame_record(7, REC_CHUNKED);
        send_record();
        // encoded byte while replay is pending
        payload = {8'd4, 8'd0, 8'h12, 8'h34};
        frame_record(4, 8'(REC_PATTERN));
        intrude_pct = 100;
        send_record();
        intrude_pct = 0;
        repeat (2) send_item(CMD_PULL, 8'($urandom), 1'b0);
        send_item(CMD_BYTE, 8'h00, 1'b0);
        drain_results();
    endtask

    // ignored items and dropped records
    task automatic test_stray_and_abort();
        send_item(CMD_BYTE, 8'h3C, 1'b0);
        send_item(CMD_PULL, 8'hFF, 1'b0);
        send_item(CMD_PULL, 8'h00, 1'b1);
        // start_req on pulls has no effect
        payload = {8'd2, 8'd0, 8'h11, 8'h22};
        frame_record(4, 8'(REC_PATTERN));
        intrude_pct = 100;
        send_record();
        repeat (4) send_item(CMD_PULL, 8'($urandom), 1'b1);
        // raw record dropped mid payload
        payload = {8'h01, 8'h02, 8'h03};
        frame_record(16'hFFFF, 8'(REC_RAW));
        send_record();
        // pattern record dropped mid replay
        payload = {8'd5, 8'd0, 8'hAA, 8'hBB};
        frame_record(4, 8'(REC_PATTERN));
        send_record();
        repeat (2) send_item(CMD_PULL, 8'($urandom), 1'b0);
        intrude_pct = 0;
        payload = {8'h77};
        frame_record(2, 8'(REC_RAW));
        send_record();
        drain_results();
    endtask

    // random records, mostly well formed, with noise, cuts and intrusions
    task automatic test_random_records();
        int unsigned target;
        int          nrec, r, cut;
        target = 1900;
        nrec = 0;
        while (effective_items < target) begin
            if (nrec % 40 == 0) begin
                r = $urandom_range(0, 2);
                src_idle_pct  = (r == 0) ? 0 : (r == 1) ? 15 : 40;
                r = $urandom_range(0, 2);
                snk_stall_pct = (r == 0) ? 0 : (r == 1) ? 15 : 40;
            end
            if (nrec % 60 == 59) drain_results();
            intrude_pct = ($urandom_range(0, 99) < 85) ? 0 : 10;
            build_random_record();
            if ($urandom_range(0, 99) < 6 && rec_bytes.size() > 1) begin
                cut = $urandom_range(1, rec_bytes.size() - 1);
                rec_bytes = rec_bytes[0:cut-1];
            end
            send_record();
            r = $urandom_range(0, 99);
            if (r < 8) send_item(CMD_PULL, 8'($urandom), 1'($urandom));
            else if (r < 14) send_item(CMD_BYTE, 8'($urandom), 1'b0);
            nrec++;
        end
        intrude_pct = 0;
        drain_results();
    endtask

    initial begin
        i_rst_n          = 1'b0;
        src_ch.valid     = 1'b0;
        src_ch.command   = CMD_BYTE;
        src_ch.in_byte   = 8'd0;
        src_ch.start_req = 1'b0;
        clear_decoder();
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        src_idle_pct  = 20;
        snk_stall_pct = 20;
        test_raw_records();
        test_pattern_records();
        test_chunk_records();
        test_error_closes();
        test_stray_and_abort();
        test_random_records();
        drain_results();
        repeat (10) @(negedge i_clk);
        if (mismatch_count == 0 && expanded_q.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // watchdog
    initial begin
        #10_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
